### design/lps_pkg.sv
`timescale 1ns / 1ps

package lps_pkg;

  // mode codes, also shown on active_mode
  localparam logic [3:0] MODE_BIN_UP  = 4'd0;
  localparam logic [3:0] MODE_BIN_DN  = 4'd1;
  localparam logic [3:0] MODE_GRAY_UP = 4'd2;
  localparam logic [3:0] MODE_GRAY_DN = 4'd3;
  localparam logic [3:0] MODE_BCD_UP  = 4'd4;
  localparam logic [3:0] MODE_BCD_DN  = 4'd5;
  localparam logic [3:0] MODE_SNAKE   = 4'd6;
  localparam logic [3:0] MODE_FILL    = 4'd7;
  localparam logic [3:0] MODE_LFSR    = 4'd8;

  localparam logic [7:0] LFSR_TAPS_RST = 8'd57;
  localparam logic [3:0] SNAKE_LAST    = 4'd10;
  localparam logic [7:0] BCD_MAX       = 8'd99;
  localparam logic [7:0] BCD_DN_START  = 8'd100;

  typedef struct packed {
    logic next_pressed;
    logic prev_pressed;
  } lps_in_t;

  typedef struct packed {
    logic [7:0] led_pattern;
    logic [3:0] active_mode;
  } lps_out_t;

  // three-led snake steps
  function automatic logic [7:0] snake_step(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0:    r = 8'd7;
      4'd1:    r = 8'd14;
      4'd2:    r = 8'd28;
      4'd3:    r = 8'd56;
      4'd4:    r = 8'd112;
      4'd5:    r = 8'd224;
      4'd6:    r = 8'd112;
      4'd7:    r = 8'd56;
      4'd8:    r = 8'd28;
      4'd9:    r = 8'd14;
      4'd10:   r = 8'd7;
      default: r = 8'd7;
    endcase
    return r;
  endfunction

  // stacked leds already settled at each fill level
  function automatic logic [7:0] fill_base(input logic [2:0] lvl);
    logic [7:0] r;
    unique case (lvl)
      3'd0:    r = 8'd0;
      3'd1:    r = 8'd128;
      3'd2:    r = 8'd192;
      3'd3:    r = 8'd224;
      3'd4:    r = 8'd240;
      3'd5:    r = 8'd248;
      3'd6:    r = 8'd252;
      default: r = 8'd254;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] to_gray(input logic [7:0] v);
    return v ^ (v >> 1);
  endfunction

  // two-digit bcd for 0..99, tens by reciprocal multiply (205/2048)
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [3:0]  tens;
    logic [7:0]  units;
    prod  = 16'(v) * 16'd205;
    tens  = prod[14:11];
    units = v - 8'(tens) * 8'd10;
    return {tens, units[3:0]};
  endfunction

endpackage

### design/lps_core.sv
`timescale 1ns / 1ps

module lps_core
  import lps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  lps_in_t    in_word_i,
  input  logic [7:0] taps_i,
  output lps_out_t   result_o
);

  logic [3:0] mode_q, mode_d;
  logic [7:0] wv_q, wv_d;
  logic [3:0] step_q, step_d;
  logic [2:0] bit_q, bit_d;
  logic       entered_q, entered_d;

  logic [7:0] wv_e;
  logic [3:0] step_e;
  logic [2:0] bit_e;
  logic [7:0] pat;
  logic [7:0] inc, dec, bcd_v;
  logic [3:0] snake_idx;
  logic [2:0] lvl;
  logic [3:0] bi_inc;

  // restart values on mode entry
  always_comb begin
    wv_e   = wv_q;
    step_e = step_q;
    bit_e  = bit_q;
    if (entered_q) begin
      unique case (mode_q)
        MODE_BIN_UP, MODE_GRAY_UP, MODE_BCD_UP: wv_e = 8'd255;
        MODE_BIN_DN, MODE_GRAY_DN:              wv_e = 8'd0;
        MODE_BCD_DN:                            wv_e = BCD_DN_START;
        MODE_SNAKE:                             step_e = 4'd0;
        MODE_FILL: begin
          step_e = 4'd0;
          bit_e  = 3'd0;
        end
        default: ;
      endcase
    end
  end

  assign inc       = wv_e + 8'd1;
  assign dec       = wv_e - 8'd1;
  assign snake_idx = (step_e > SNAKE_LAST) ? 4'd0 : step_e;
  assign lvl       = step_e[2:0];
  assign bi_inc    = {1'b0, bit_e} + 4'd1;

  // pattern and next working state for the current mode
  always_comb begin
    wv_d   = wv_e;
    step_d = step_e;
    bit_d  = bit_e;
    bcd_v  = 8'd0;
    pat    = 8'd0;
    unique case (mode_q)
      MODE_BIN_UP: begin
        wv_d = inc;
        pat  = inc;
      end
      MODE_BIN_DN: begin
        wv_d = dec;
        pat  = dec;
      end
      MODE_GRAY_UP: begin
        wv_d = inc;
        pat  = to_gray(inc);
      end
      MODE_GRAY_DN: begin
        wv_d = dec;
        pat  = to_gray(dec);
      end
      MODE_BCD_UP: begin
        bcd_v = (inc > BCD_MAX) ? 8'd0 : inc;
        pat   = to_bcd(bcd_v);
        wv_d  = (bcd_v >= BCD_MAX) ? 8'd255 : bcd_v;
      end
      MODE_BCD_DN: begin
        bcd_v = ((wv_e == 8'd0) || (wv_e > BCD_DN_START)) ? BCD_MAX : dec;
        pat   = to_bcd(bcd_v);
        wv_d  = (bcd_v == 8'd0) ? BCD_DN_START : bcd_v;
      end
      MODE_SNAKE: begin
        pat    = snake_step(snake_idx);
        wv_d   = pat;
        step_d = (snake_idx >= SNAKE_LAST) ? 4'd0 : snake_idx + 4'd1;
      end
      MODE_FILL: begin
        pat  = fill_base(lvl) | (8'd1 << bit_e);
        wv_d = pat;
        if (bi_inc >= (4'd8 - {1'b0, lvl})) begin
          bit_d  = 3'd0;
          step_d = {1'b0, lvl + 3'd1};
        end else begin
          bit_d  = bi_inc[2:0];
          step_d = {1'b0, lvl};
        end
      end
      default: begin
        wv_d = (wv_e >> 1) ^ (wv_e[0] ? taps_i : 8'd0);
        pat  = wv_d;
      end
    endcase
  end

  // button handling, next wins except both in fill restarts it
  always_comb begin
    mode_d    = mode_q;
    entered_d = 1'b0;
    priority if ((mode_q == MODE_FILL) && in_word_i.next_pressed
                 && in_word_i.prev_pressed) begin
      entered_d = 1'b1;
    end else if (in_word_i.next_pressed) begin
      mode_d    = (mode_q >= MODE_LFSR) ? MODE_BIN_UP : mode_q + 4'd1;
      entered_d = 1'b1;
    end else if (in_word_i.prev_pressed) begin
      mode_d    = ((mode_q == MODE_BIN_UP) || (mode_q > MODE_LFSR)) ? MODE_LFSR
                                                                    : mode_q - 4'd1;
      entered_d = 1'b1;
    end
  end

  assign result_o.led_pattern = pat;
  assign result_o.active_mode = mode_q;

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_BIN_UP;
      wv_q      <= 8'd1;
      step_q    <= 4'd0;
      bit_q     <= 3'd0;
      entered_q <= 1'b1;
    end else if (accept_i) begin
      mode_q    <= mode_d;
      wv_q      <= wv_d;
      step_q    <= step_d;
      bit_q     <= bit_d;
      entered_q <= entered_d;
    end
  end

endmodule

### design/lps_outbuf.sv
`timescale 1ns / 1ps

module lps_outbuf
  import lps_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lps_out_t push_word_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lps_out_t out_word_o
);

  logic     out_valid_q;
  logic     skid_valid_q;
  lps_out_t out_q;
  lps_out_t skid_q;
  logic     pop;

  assign pop         = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // occupancy of output and skid stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (!push_i) begin
        out_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // word storage
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_word_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_q <= push_word_i;
      end else begin
        out_q <= push_word_i;
      end
    end
  end

endmodule

### design/led_pattern_sequencer_unit.sv
`timescale 1ns / 1ps
// a result word is registered in the output stage, or in the skid stage while stalled
// throughput: one word per cycle while the output buffer is not full
// a two-word output buffer keeps input flowing while one result is stalled
// reset (rst_ni low, asynchronous) starts in binary up mode with taps 57
// config writes are always ready and take effect on the next word

module led_pattern_sequencer_unit
  import lps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  lps_in_t    in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output lps_out_t   out_word_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic     [7:0] taps_q;
  logic           accept;
  logic           full;
  lps_out_t       result;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  // lfsr tap mask register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= LFSR_TAPS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      taps_q <= cfg_data_i;
    end
  end

  lps_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_word_i (in_word_i),
    .taps_i    (taps_q),
    .result_o  (result)
  );

  lps_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_word_i (result),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
